[design/stereo_fir_filter_core_defines.svh]
// ---------------------------------------------------------------------------
// stereo fir filter core assertion macros
// shared property forms for the checker, clocked on clk, held off in reset
// ---------------------------------------------------------------------------
`ifndef STEREO_FIR_FILTER_CORE_DEFINES_SVH
`define STEREO_FIR_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define SFF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sff_pkg.sv]
// ---------------------------------------------------------------------------
// sff_pkg
// shared constants and types of the stereo fir filter core
// ---------------------------------------------------------------------------
package sff_pkg;

	localparam int MAX_HALF_DEF   = 1024;
	localparam int COEF_FRAC_DEF  = 16;

	localparam int HALF_LEN_W     = 11;
	localparam int TAP_W          = 12;
	localparam int COEF_W         = 18;
	localparam int SAMPLE_W       = 16;
	localparam int S_TDATA_W      = 64;
	localparam int M_TDATA_W      = 32;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	localparam logic [HALF_LEN_W-1:0] HALF_LEN_RESET = 11'd8;

	// register word index (paddr[2])
	localparam logic REG_HALF_LEN = 1'b0;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PUSH = 1'b1;

	localparam logic CH_LEFT  = 1'b0;
	localparam logic CH_RIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_PUSH_WR,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_DONE
	} state_t;

endpackage

[design/sff_ram.sv]
// ---------------------------------------------------------------------------
// sff_ram
// single-port synchronous ram, registered read
// ---------------------------------------------------------------------------
module sff_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2049
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[design/stereo_fir_filter_core.sv]
// ---------------------------------------------------------------------------
// stereo_fir_filter_core
// two direct-form fir filters (left, right) with 2*M+1 taps each, sharing
// one coefficient ram and one sample history ram, one mac per channel
// ---------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  apb       in   psel/penable/pready     paddr, pwdata, prdata (half_len)
//  s_ item   in   s_tvalid/s_tready       s_tuser (cmd), s_tdata
//  m_ item   out  m_tvalid/m_tready       m_tdata (left_out, right_out)
//
//  push: one tap per cycle through the single read port of each ram.
//  load: read, merge, write back; nothing is written when the tap index
//  is beyond the table.
//  reset: a clearing pass zeroes all 2*MAX_HALF+1 history ram entries
//  (2049 by default), s_tready low meanwhile; apb writes are taken.
//  the result register holds under m_tready low; the next item is accepted
//  meanwhile, and a later push waits in its last stage until it is free.
// ---------------------------------------------------------------------------
module stereo_fir_filter_core #(
	parameter int MAX_HALF       = sff_pkg::MAX_HALF_DEF,
	parameter int COEF_FRAC_BITS = sff_pkg::COEF_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sff_pkg::PADDR_W-1:0]   paddr,
	input  logic [sff_pkg::PDATA_W-1:0]   pwdata,
	output logic [sff_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// coef_channel[0], tap_index[12:1], coef_value[30:13],
	// left_sample[46:31], right_sample[62:47], zero[63]
	input  logic [sff_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd[0]
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// left_out[15:0], right_out[31:16]
	output logic [sff_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int DEPTH     = 2 * MAX_HALF + 1;
	localparam int AW        = $clog2(DEPTH);
	localparam int MW        = $clog2(MAX_HALF + 1);
	localparam int HL_W      = (MW > sff_pkg::HALF_LEN_W) ? MW : sff_pkg::HALF_LEN_W;
	localparam int TC_W      = (AW + 1 > sff_pkg::TAP_W) ? AW + 1 : sff_pkg::TAP_W;
	localparam int CW        = sff_pkg::COEF_W;
	localparam int SW        = sff_pkg::SAMPLE_W;
	localparam int PROD_W    = CW + SW;
	localparam int ACC_W     = PROD_W + AW;
	localparam int MAG_W     = ACC_W + 1;

	// input fields
	logic                 in_cmd;
	logic                 in_ch;
	logic [sff_pkg::TAP_W-1:0] in_tap;
	logic signed [CW-1:0] in_coef;
	logic signed [SW-1:0] in_left;
	logic signed [SW-1:0] in_right;
	logic                 tap_ok;

	assign in_cmd   = s_tuser[0];
	assign in_ch    = s_tdata[0];
	assign in_tap   = s_tdata[12:1];
	assign in_coef  = s_tdata[30:13];
	assign in_left  = s_tdata[46:31];
	assign in_right = s_tdata[62:47];
	assign tap_ok   = TC_W'(in_tap) < TC_W'(DEPTH);

	// configuration
	logic [sff_pkg::HALF_LEN_W-1:0] half_len_q;
	logic                           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == sff_pkg::REG_HALF_LEN);
	assign prdata = (paddr[2] == sff_pkg::REG_HALF_LEN) ?
		sff_pkg::PDATA_W'(half_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_len_q <= sff_pkg::HALF_LEN_RESET;
		end else if (cfg_wr) begin
			half_len_q <= pwdata[sff_pkg::HALF_LEN_W-1:0];
		end
	end

	// tap count
	logic [HL_W-1:0] hl_ext;
	logic [HL_W-1:0] m_sat;
	logic [AW-1:0]   last_tap;

	assign hl_ext   = HL_W'(half_len_q);
	assign m_sat    = (hl_ext > HL_W'(MAX_HALF)) ? HL_W'(MAX_HALF) : hl_ext;
	assign last_tap = AW'(m_sat) << 1;

	// control state
	sff_pkg::state_t state_q, state_d;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   ptr_nx;
	logic [AW-1:0]   k_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   last_q;
	logic            rd_v_s1;
	logic            prod_v_s2;
	logic            m_tvalid_q;

	// payload
	logic                 ld_ch_q;
	logic [AW-1:0]        ld_tap_q;
	logic signed [CW-1:0] ld_coef_q;
	logic [2*SW-1:0]      smp_q;
	logic signed [PROD_W-1:0] prod_s2 [2];
	logic signed [ACC_W-1:0]  acc_q [2];
	logic [MAG_W-1:0]     mag_q [2];
	logic                 neg_q [2];
	logic [sff_pkg::M_TDATA_W-1:0] m_tdata_q;

	// rams
	logic            coef_we;
	logic [AW-1:0]   coef_addr;
	logic [2*CW-1:0] coef_wdata;
	logic [2*CW-1:0] coef_rdata;
	logic            hist_we;
	logic [AW-1:0]   hist_addr;
	logic [2*SW-1:0] hist_wdata;
	logic [2*SW-1:0] hist_rdata;

	// fsm outputs
	logic accept;
	logic issue;
	logic out_load;

	assign ptr_nx = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		coef_we    = 1'b0;
		coef_addr  = k_q;
		coef_wdata = (ld_ch_q == sff_pkg::CH_RIGHT) ? {ld_coef_q, coef_rdata[CW-1:0]}
			: {coef_rdata[2*CW-1:CW], ld_coef_q};
		hist_we    = 1'b0;
		hist_addr  = idx_q;
		hist_wdata = smp_q;
		issue      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			sff_pkg::ST_CLEAR: begin
				hist_we    = 1'b1;
				hist_addr  = clr_q;
				hist_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = sff_pkg::ST_IDLE;
				end
			end
			sff_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_cmd == sff_pkg::CMD_PUSH) begin
						state_d = sff_pkg::ST_PUSH_WR;
					end else if (tap_ok) begin
						state_d = sff_pkg::ST_LOAD_RD;
					end
				end
			end
			sff_pkg::ST_LOAD_RD: begin
				coef_addr = ld_tap_q;
				state_d   = sff_pkg::ST_LOAD_WR;
			end
			sff_pkg::ST_LOAD_WR: begin
				coef_addr = ld_tap_q;
				coef_we   = 1'b1;
				state_d   = sff_pkg::ST_IDLE;
			end
			sff_pkg::ST_PUSH_WR: begin
				hist_addr = ptr_q;
				hist_we   = 1'b1;
				state_d   = sff_pkg::ST_MAC;
			end
			sff_pkg::ST_MAC: begin
				issue = 1'b1;
				if (k_q == last_q) begin
					state_d = sff_pkg::ST_DRAIN;
				end
			end
			sff_pkg::ST_DRAIN: begin
				if (!rd_v_s1 && !prod_v_s2) begin
					state_d = sff_pkg::ST_ROUND;
				end
			end
			sff_pkg::ST_ROUND: begin
				state_d = sff_pkg::ST_DONE;
			end
			sff_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = sff_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sff_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sff_pkg::ST_CLEAR;
			clr_q      <= '0;
			ptr_q      <= '0;
			k_q        <= '0;
			idx_q      <= '0;
			last_q     <= '0;
			rd_v_s1    <= 1'b0;
			prod_v_s2  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_v_s1   <= issue;
			prod_v_s2 <= rd_v_s1;
			if (state_q == sff_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept && in_cmd == sff_pkg::CMD_PUSH) begin
				ptr_q  <= ptr_nx;
				idx_q  <= ptr_nx;
				k_q    <= '0;
				last_q <= last_tap;
			end else if (issue) begin
				k_q   <= k_q + AW'(1);
				idx_q <= (idx_q == '0) ? AW'(DEPTH - 1) : idx_q - AW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath, one lane per channel
	logic signed [CW-1:0] coef_lane [2];
	logic signed [SW-1:0] hist_lane [2];
	logic [MAG_W-1:0]     mag_abs [2];
	logic [MAG_W-1:0]     mag_rnd [2];
	logic [SW-1:0]        sat_out [2];

	assign coef_lane[0] = coef_rdata[CW-1:0];
	assign coef_lane[1] = coef_rdata[2*CW-1:CW];
	assign hist_lane[0] = hist_rdata[SW-1:0];
	assign hist_lane[1] = hist_rdata[2*SW-1:SW];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			mag_abs[c] = acc_q[c][ACC_W-1] ? MAG_W'(-acc_q[c]) : MAG_W'(acc_q[c]);
			mag_abs[c] = {1'b0, mag_abs[c][ACC_W-1:0]};
			mag_rnd[c] = (mag_abs[c] + (MAG_W'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
			if (neg_q[c]) begin
				sat_out[c] = (mag_q[c] > MAG_W'(32768)) ? 16'h8000 : SW'(-mag_q[c]);
			end else begin
				sat_out[c] = (mag_q[c] > MAG_W'(32767)) ? 16'h7fff : mag_q[c][SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ld_ch_q   <= in_ch;
			ld_tap_q  <= AW'(in_tap);
			ld_coef_q <= in_coef;
			smp_q     <= {in_right, in_left};
		end
		for (int c = 0; c < 2; c++) begin
			if (rd_v_s1) begin
				prod_s2[c] <= PROD_W'(coef_lane[c]) * PROD_W'(hist_lane[c]);
			end
			if (accept && in_cmd == sff_pkg::CMD_PUSH) begin
				acc_q[c] <= '0;
			end else if (prod_v_s2) begin
				acc_q[c] <= acc_q[c] + ACC_W'(prod_s2[c]);
			end
			if (state_q == sff_pkg::ST_ROUND) begin
				neg_q[c] <= acc_q[c][ACC_W-1];
				mag_q[c] <= mag_rnd[c];
			end
		end
		if (out_load) begin
			m_tdata_q <= {sat_out[1], sat_out[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	sff_ram #(
		.WIDTH (2 * CW),
		.DEPTH (DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.addr  (coef_addr),
		.wdata (coef_wdata),
		.rdata (coef_rdata)
	);

	sff_ram #(
		.WIDTH (2 * SW),
		.DEPTH (DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.addr  (hist_addr),
		.wdata (hist_wdata),
		.rdata (hist_rdata)
	);

endmodule

[design/sff_checker.sv]
// ---------------------------------------------------------------------------
// sff_checker
// port-level checks of the stereo fir filter core, bound to the top level
// ---------------------------------------------------------------------------
`include "stereo_fir_filter_core_defines.svh"

module sff_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [sff_pkg::PADDR_W-1:0]   paddr,
	input logic [sff_pkg::PDATA_W-1:0]   pwdata,
	input logic [sff_pkg::PDATA_W-1:0]   prdata,
	input logic                          pready,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [sff_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [0:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sff_pkg::M_TDATA_W-1:0] m_tdata
);

	// result held while stalled
	`SFF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed under stall")

	// a push occupies the block for its mac walk
	`SFF_ASSERT_NEXT(a_push_busy, s_tvalid && s_tready && (s_tuser[0] == sff_pkg::CMD_PUSH), !s_tready, "item taken right after a push")

	// register write reads back
	`SFF_ASSERT_NEXT(a_cfg_rdback, psel && penable && pwrite && pready && (paddr[2] == sff_pkg::REG_HALF_LEN), (paddr[2] != sff_pkg::REG_HALF_LEN) || (prdata[10:0] == $past(pwdata[10:0])), "half_len readback mismatch")

	// apb access never waits
	`SFF_ASSERT_NOW(a_apb_ready, psel && penable, pready, "apb access stalled")

endmodule

bind stereo_fir_filter_core sff_checker u_sff_checker (.*);
